/* rtl/core/hpz_pkg.sv */
// Package of the harmonic phase and zero-crossing block.
// Holds register indexes, reset values, arithmetic constants and the ring result type.
// Depends on nothing.
`default_nettype none
package hpz_pkg;

	// configuration register indexes
	localparam logic [1:0] REG_SRC_H1   = 2'd0;
	localparam logic [1:0] REG_SRC_HIGH = 2'd1;
	localparam logic [1:0] REG_TRG_H1   = 2'd2;
	localparam logic [1:0] REG_TRG_HIGH = 2'd3;

	// register reset values in picoseconds
	localparam logic [23:0] RST_SRC_H1   = 24'd1272102;
	localparam logic [23:0] RST_SRC_HIGH = 24'd636051;
	localparam logic [23:0] RST_TRG_H1   = 24'd6361320;
	localparam logic [23:0] RST_TRG_HIGH = 24'd636132;

	// one full turn of phase, and picoseconds per 8 ns tick
	localparam logic [15:0] PHASE_FULL = 16'hFFFF;
	localparam logic [13:0] TICK_PS    = 14'd8000;

	// ceil(2^25 / 125): span / 8000 is (span >> 6) * TICK_RECIP >> 25, exact
	// for any 24-bit span
	localparam logic [18:0] TICK_RECIP = 19'd268436;

	// result of one ring
	typedef struct packed {
		logic [48:0] zero_time;
		logic [15:0] high_phase;
	} ring_res_t;

endpackage
`default_nettype wire

/* rtl/core/harmonic_phase_and_zero_crossing.sv */
// Harmonic phase and zero-crossing calculator. Takes one item per cycle while
// no result waits at the output, and delivers results in order: one multiply
// stage, one stage that folds the product into the offset (division by one
// turn), bit-per-cell division chains of 24 and 40 cells per ring (both rings
// run side by side), one reciprocal-multiply stage for the tick count, then the
// output register. The whole pipeline advances together and holds while a
// result waits at the output. Periods must be written through the cfg port
// only while no item is in flight; the block itself does not enforce this.
// Depends on hpz_pkg and hpz_ring.
`default_nettype none
module harmonic_phase_and_zero_crossing import hpz_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_we,
	input  wire logic [1:0]   cfg_index,
	input  wire logic [23:0]  cfg_data,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// src_h1_phase[15:0], trg_h1_phase[31:16], predict_time[79:32]
	input  wire logic [79:0]  s_tdata,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// src_high_phase[15:0], trg_high_phase[31:16], src_zero_time[80:32],
	// trg_zero_time[129:81], zero[135:130]
	output logic [135:0]      m_tdata
);

	logic [23:0] src_h1_q, src_high_q, trg_h1_q, trg_high_q;
	logic        en;
	logic        in_valid;
	logic        src_valid, trg_valid;
	ring_res_t   src_res, trg_res;
	logic        out_valid_q;
	logic [129:0] out_data_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_h1_q   <= RST_SRC_H1;
			src_high_q <= RST_SRC_HIGH;
			trg_h1_q   <= RST_TRG_H1;
			trg_high_q <= RST_TRG_HIGH;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SRC_H1:   src_h1_q   <= cfg_data;
				REG_SRC_HIGH: src_high_q <= cfg_data;
				REG_TRG_H1:   trg_h1_q   <= cfg_data;
				REG_TRG_HIGH: trg_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// advance unless a result waits unread
	assign en       = !out_valid_q || m_tready;
	assign s_tready = en;
	assign in_valid = s_tvalid;

	hpz_ring u_src (
		.clk (clk), .arst_n (arst_n), .en (en), .p1 (src_h1_q), .ph (src_high_q),
		.in_valid (in_valid), .phase (s_tdata[15:0]), .t (s_tdata[79:32]),
		.out_valid (src_valid), .res (src_res)
	);

	hpz_ring u_trg (
		.clk (clk), .arst_n (arst_n), .en (en), .p1 (trg_h1_q), .ph (trg_high_q),
		.in_valid (in_valid), .phase (s_tdata[31:16]), .t (s_tdata[79:32]),
		.out_valid (trg_valid), .res (trg_res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= src_valid && trg_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data_q <= {trg_res.zero_time, src_res.zero_time,
				trg_res.high_phase, src_res.high_phase};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, out_data_q};

endmodule
`default_nettype wire

/* rtl/core/hpz_cell.sv */
// One restoring division cell: takes one numerator bit, makes one quotient bit.
// Carries the item's side data to its neighbor. No dependencies.
`default_nettype none
module hpz_cell #(
	parameter int NW = 40,
	parameter int DW = 24,
	parameter int PW = 48
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic [DW-1:0] d,
	input  wire logic          in_valid,
	input  wire logic [DW-1:0] in_rem,
	input  wire logic [NW-1:0] in_nq,
	input  wire logic [PW-1:0] in_pay,
	output logic               out_valid,
	output logic [DW-1:0]      out_rem,
	output logic [NW-1:0]      out_nq,
	output logic [PW-1:0]      out_pay
);

	logic [DW:0]   trial;
	logic [DW:0]   diff;
	logic          ge;
	logic [DW-1:0] rem_n;
	logic          valid_q;
	logic [DW-1:0] rem_q;
	logic [NW-1:0] nq_q;
	logic [PW-1:0] pay_q;

	// shift in the next numerator bit, subtract the divisor where it fits
	always_comb begin
		trial = {in_rem, in_nq[NW-1]};
		diff  = trial - {1'b0, d};
		ge    = (trial >= {1'b0, d});
		rem_n = ge ? diff[DW-1:0] : trial[DW-1:0];
	end

	// hold the valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	// advance remainder, numerator/quotient word and side data
	always_ff @(posedge clk) begin
		if (en) begin
			rem_q <= rem_n;
			nq_q  <= {in_nq[NW-2:0], ge};
			pay_q <= in_pay;
		end
	end

	assign out_valid = valid_q;
	assign out_rem   = rem_q;
	assign out_nq    = nq_q;
	assign out_pay   = pay_q;

endmodule
`default_nettype wire

/* rtl/core/hpz_div.sv */
// Pipelined divider: a row of NW division cells, one quotient bit per cell.
// Depends on hpz_cell.
`default_nettype none
module hpz_div #(
	parameter int NW = 40,
	parameter int DW = 24,
	parameter int PW = 48
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic [DW-1:0] d,
	input  wire logic          in_valid,
	input  wire logic [NW-1:0] in_num,
	input  wire logic [PW-1:0] in_pay,
	output logic               out_valid,
	output logic [NW-1:0]      out_quo,
	output logic [DW-1:0]      out_rem,
	output logic [PW-1:0]      out_pay
);

	logic          valid_w [0:NW];
	logic [DW-1:0] rem_w   [0:NW];
	logic [NW-1:0] nq_w    [0:NW];
	logic [PW-1:0] pay_w   [0:NW];

	assign valid_w[0] = in_valid;
	assign rem_w[0]   = '0;
	assign nq_w[0]    = in_num;
	assign pay_w[0]   = in_pay;

	// chain the cells, most significant numerator bit first
	for (genvar k = 0; k < NW; k++) begin : g_cell
		hpz_cell #(.NW(NW), .DW(DW), .PW(PW)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.d         (d),
			.in_valid  (valid_w[k]),
			.in_rem    (rem_w[k]),
			.in_nq     (nq_w[k]),
			.in_pay    (pay_w[k]),
			.out_valid (valid_w[k+1]),
			.out_rem   (rem_w[k+1]),
			.out_nq    (nq_w[k+1]),
			.out_pay   (pay_w[k+1])
		);
	end

	assign out_valid = valid_w[NW];
	assign out_quo   = nq_w[NW];
	assign out_rem   = rem_w[NW];
	assign out_pay   = pay_w[NW];

endmodule
`default_nettype wire

/* rtl/core/hpz_ring.sv */
// Per-ring datapath: multiply, fold the product into the offset, division chains
// for remainder and high-harmonic phase, reciprocal multiply for the tick count.
// Depends on hpz_pkg and hpz_div.
`default_nettype none
module hpz_ring import hpz_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        en,
	input  wire logic [23:0] p1,
	input  wire logic [23:0] ph,
	input  wire logic        in_valid,
	input  wire logic [15:0] phase,
	input  wire logic [47:0] t,
	output logic             out_valid,
	output ring_res_t        res
);

	logic        valid_s1;
	logic [39:0] prod_s1;
	logic [47:0] t_s1;
	logic [24:0] fold_a;
	logic [16:0] fold_b;
	logic [23:0] x_n;
	logic        valid_s2;
	logic [23:0] x_s2;
	logic [47:0] t_s2;
	logic        v2, v3;
	logic [47:0] t2;
	logic [23:0] r2;
	logic [39:0] n3;
	logic [39:0] q3;
	logic [71:0] pay3;
	logic [23:0] n4;
	logic [36:0] tick_prod;
	logic        valid_s3;
	logic [11:0] ticks_s3;
	logic [47:0] t_s3;
	logic [15:0] phase_s3;

	// hold the multiply and offset stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	// phase times first-harmonic period
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= {24'd0, phase} * {16'd0, p1};
			t_s1    <= t;
		end
	end

	// offset x = product / one turn: fold the 2^16 = one turn + 1 carries back in
	always_comb begin
		fold_a = {1'b0, prod_s1[39:16]} + {9'd0, prod_s1[15:0]};
		fold_b = {8'd0, fold_a[24:16]} + {1'b0, fold_a[15:0]};
		x_n    = prod_s1[39:16] + {15'd0, fold_a[24:16]}
			+ {23'd0, (fold_b >= {1'b0, PHASE_FULL})};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s2 <= x_n;
			t_s2 <= t_s1;
		end
	end

	// remainder r = x mod high period
	hpz_div #(.NW(24), .DW(24), .PW(48)) u_div_r (
		.clk (clk), .arst_n (arst_n), .en (en), .d (ph),
		.in_valid (valid_s2), .in_num (x_s2), .in_pay (t_s2),
		.out_valid (v2), .out_quo (), .out_rem (r2), .out_pay (t2)
	);

	// high phase = r * one turn / high period
	assign n3 = {r2, 16'd0} - {16'd0, r2};

	hpz_div #(.NW(40), .DW(24), .PW(72)) u_div_p (
		.clk (clk), .arst_n (arst_n), .en (en), .d (ph),
		.in_valid (v2), .in_num (n3), .in_pay ({t2, r2}),
		.out_valid (v3), .out_quo (q3), .out_rem (), .out_pay (pay3)
	);

	// ticks to next crossing = (high period - r) / 8000 by reciprocal multiply
	assign n4        = ph - pay3[23:0];
	assign tick_prod = {19'd0, n4[23:6]} * {18'd0, TICK_RECIP};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= v3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ticks_s3 <= tick_prod[36:25];
			t_s3     <= pay3[71:24];
			phase_s3 <= q3[15:0];
		end
	end

	// add to the timestamp; a zero high period gives phase 0 and the timestamp
	always_comb begin
		if (ph == 24'd0) begin
			res.high_phase = 16'd0;
			res.zero_time  = {1'b0, t_s3};
		end else begin
			res.high_phase = phase_s3;
			res.zero_time  = {1'b0, t_s3} + {37'd0, ticks_s3};
		end
	end

	assign out_valid = valid_s3;

endmodule
`default_nettype wire

/* rtl/core/hpz_checker.sv */
// Port-level checks of the harmonic phase and zero-crossing block, and their bind.
// Depends on the top level's ports only.
`default_nettype none
module hpz_checker (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         s_tready,
	input wire logic         m_tvalid,
	input wire logic         m_tready,
	input wire logic [135:0] m_tdata
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// input side stalls exactly when a result waits
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("input ready does not follow output side");

	// padding bits stay zero
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[135:130] == 6'd0)
		else $error("padding bits set");

endmodule

bind harmonic_phase_and_zero_crossing hpz_checker u_hpz_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
`default_nettype wire

/* sim/harmonic_phase_and_zero_crossing_tb.sv */
// Testbench for the harmonic phase and zero-crossing block.
// Runs directed and random phase items through several period settings and checks
// every result against a local predictor. Depends on hpz_pkg and the block's RTL.
`default_nettype none
module harmonic_phase_and_zero_crossing_tb;
	import hpz_pkg::*;

	typedef struct {
		logic [15:0] src_phase;
		logic [15:0] trg_phase;
		logic [48:0] src_time;
		logic [48:0] trg_time;
	} crossing_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [23:0] cfg_data;
	logic s_tvalid;
	logic s_tready;
	logic [79:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [135:0] m_tdata;

	// local copy of the period registers
	logic [23:0] src_h1_ps, src_high_ps, trg_h1_ps, trg_high_ps;

	crossing_t crossing_q[$];
	int err_count;
	int burst_left;
	int ready_mode;

	harmonic_phase_and_zero_crossing u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always #2 clk = ~clk;

	// offset of one ring within its high-harmonic period, and what follows from it
	task automatic ring_predict(input logic [15:0] phase, input logic [23:0] p1,
			input logic [23:0] ph, input logic [47:0] t,
			output logic [15:0] high_phase, output logic [48:0] zero_time);
		logic [63:0] offs;
		logic [63:0] rem;
		if (ph == 0) begin
			high_phase = '0;
			zero_time = {1'b0, t};
		end else begin
			offs = (64'(phase) * 64'(p1)) / 64'(PHASE_FULL);
			rem = offs % 64'(ph);
			high_phase = 16'((rem * 64'(PHASE_FULL)) / 64'(ph));
			zero_time = 49'(64'(t) + (64'(ph) - rem) / 64'(TICK_PS));
		end
	endtask

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("mismatch %s: got %0h, want %0h", what, got, want);
		err_count++;
	endtask

	// drive one item, wait for acceptance, then queue its prediction
	task automatic send_item(input logic [15:0] sp, input logic [15:0] tp,
			input logic [47:0] t);
		crossing_t c;
		int gap;
		s_tvalid <= 1'b1;
		s_tdata <= {t, tp, sp};
		do @(posedge clk); while (!s_tready);
		ring_predict(sp, src_h1_ps, src_high_ps, t, c.src_phase, c.src_time);
		ring_predict(tp, trg_h1_ps, trg_high_ps, t, c.trg_phase, c.trg_time);
		crossing_q.push_back(c);
		// burst control: drop valid for a random gap when the burst runs out
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 20);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// drain the pipeline, then write one register
	task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
		s_tvalid <= 1'b0;
		while (crossing_q.size() != 0) @(posedge clk);
		repeat (140) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_SRC_H1:   src_h1_ps = val;
			REG_SRC_HIGH: src_high_ps = val;
			REG_TRG_H1:   trg_h1_ps = val;
			REG_TRG_HIGH: trg_high_ps = val;
			default: ;
		endcase
	endtask

	task automatic set_periods(input logic [23:0] s1, input logic [23:0] sh,
			input logic [23:0] t1, input logic [23:0] th);
		write_reg(REG_SRC_H1, s1);
		write_reg(REG_SRC_HIGH, sh);
		write_reg(REG_TRG_H1, t1);
		write_reg(REG_TRG_HIGH, th);
	endtask

	function automatic logic [15:0] rand_phase();
		case ($urandom_range(0, 5))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [47:0] rand_time();
		logic [47:0] t;
		t = {16'($urandom), 32'($urandom)};
		if ($urandom_range(0, 7) == 0) t = 48'hFFFF_FFFF_FFFF - 48'($urandom_range(0, 200));
		return t;
	endfunction

	function automatic logic [23:0] rand_period();
		case ($urandom_range(0, 7))
			0: return 24'd1;
			1: return 24'hFFFFFF;
			2: return 24'($urandom_range(1, 20000));
			default: return 24'($urandom_range(1, 24'hFFFFFF));
		endcase
	endfunction

	// directed items at reset periods: field extremes and exact multiples
	task automatic test_reset_periods();
		send_item(16'h0000, 16'h0000, 48'd0);
		send_item(16'hFFFF, 16'hFFFF, 48'hFFFF_FFFF_FFFF);
		send_item(16'h0000, 16'hFFFF, 48'hFFFF_FFFF_FFFF);
		send_item(16'hFFFF, 16'h0000, 48'd1);
		send_item(16'h8000, 16'h7FFF, 48'h8000_0000_0000);
		send_item(16'h5555, 16'hAAAA, 48'h5555_5555_5555);
		send_item(16'hAAAA, 16'h5555, 48'hAAAA_AAAA_AAAA);
	endtask

	// exact multiples, zero and extreme periods
	task automatic test_special_periods();
		// x is Ph or twice Ph for full phase, so the offset is an exact multiple
		set_periods(24'd640000, 24'd640000, 24'd320000, 24'd160000);
		send_item(16'hFFFF, 16'hFFFF, 48'd1000);
		send_item(16'h0000, 16'h0000, 48'hFFFF_FFFF_FFFF);
		// zero high-harmonic and first-harmonic periods
		set_periods(24'd0, 24'd0, 24'd0, 24'd0);
		send_item(16'hFFFF, 16'h1234, 48'hFFFF_FFFF_FFFF);
		send_item(16'h0001, 16'hFFFF, 48'd7);
		set_periods(24'd0, 24'hFFFFFF, 24'hFFFFFF, 24'd0);
		send_item(16'hFFFF, 16'hFFFF, 48'hFFFF_FFFF_FFFF);
		send_item(16'h4321, 16'h0000, 48'd0);
		// largest and smallest periods
		set_periods(24'hFFFFFF, 24'd1, 24'd1, 24'hFFFFFF);
		send_item(16'hFFFF, 16'hFFFF, 48'hFFFF_FFFF_FFFF);
		send_item(16'h0001, 16'h8001, 48'd3);
		set_periods(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
		send_item(16'hFFFF, 16'hFFFE, 48'hFFFF_FFFF_FFFF);
		send_item(16'h7FFF, 16'h0001, 48'd0);
	endtask

	// random items over the reset periods and a handful of random period settings
	task automatic test_random_items();
		for (int s = 0; s < 8; s++) begin
			if (s == 0) set_periods(RST_SRC_H1, RST_SRC_HIGH, RST_TRG_H1, RST_TRG_HIGH);
			else set_periods(rand_period(), rand_period(), rand_period(), rand_period());
			for (int i = 0; i < 80; i++) send_item(rand_phase(), rand_phase(), rand_time());
		end
	endtask

	// receiver stall pattern: switch between free flow, random and heavy stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			ready_mode <= 0;
		end else begin
			if ($urandom_range(0, 63) == 0) ready_mode <= $urandom_range(0, 2);
			case (ready_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= 1'($urandom_range(0, 1));
				default: m_tready <= ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	// compare each accepted result with the oldest prediction
	always @(posedge clk) begin
		crossing_t c;
		if (arst_n && m_tvalid && m_tready) begin
			if (crossing_q.size() == 0) begin
				report("unexpected result", 64'(m_tdata[63:0]), 64'd0);
			end else begin
				c = crossing_q.pop_front();
				if (m_tdata[15:0] !== c.src_phase)
					report("src_high_phase", 64'(m_tdata[15:0]), 64'(c.src_phase));
				if (m_tdata[31:16] !== c.trg_phase)
					report("trg_high_phase", 64'(m_tdata[31:16]), 64'(c.trg_phase));
				if (m_tdata[80:32] !== c.src_time)
					report("src_zero_time", 64'(m_tdata[80:32]), 64'(c.src_time));
				if (m_tdata[129:81] !== c.trg_time)
					report("trg_zero_time", 64'(m_tdata[129:81]), 64'(c.trg_time));
				if (m_tdata[135:130] !== 6'd0)
					report("padding", 64'(m_tdata[135:130]), 64'd0);
			end
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		err_count = 0;
		burst_left = 0;
		src_h1_ps = RST_SRC_H1;
		src_high_ps = RST_SRC_HIGH;
		trg_h1_ps = RST_TRG_H1;
		trg_high_ps = RST_TRG_HIGH;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_periods();
		test_special_periods();
		test_random_items();
		s_tvalid <= 1'b0;
		while (crossing_q.size() != 0) @(posedge clk);
		repeat (140) @(posedge clk);
		if (err_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	// hard stop in case the block hangs
	initial begin
		#4000000;
		$display("timeout");
		$display("status: fail");
		$finish;
	end

endmodule
`default_nettype wire
